### sv/lfu_pkg.sv
package lfu_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int CAP_W   = 5;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int READ_W  = 32;
   localparam int COUNT_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   typedef struct packed {
      logic                      action;
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        value;
   } req_item_type;

   typedef struct packed {
      logic                      hit;
      logic signed [READ_W-1:0]  read_value;
      logic                      evicted;
      logic signed [KEY_W-1:0]   evicted_key;
   } rsp_item_type;

endpackage

### sv/lfu_cache_with_lru_tiebreak.sv
// One request per cycle while the response channel is not stalled; a request
// is held in the request register, its result registered in the response one.
// Key match and lowest-count / oldest reduction over all entries are combinational.
// Reset (synchronous, active high) empties the store, sets capacity to 16
// and marks the request and response registers empty (payloads not cleared).
module lfu_cache_with_lru_tiebreak #(
   parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,  // key[31:0], value[62:32], zero[63]
   input  logic                       req_tuser,  // action: 0 get, 1 put
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,  // read_value[31:0], evicted_key[63:32]
   output logic [1:0]                 rsp_tuser,  // hit[0], evicted[1]
   // capacity register
   input  logic                       csr_wen,
   input  logic [lfu_pkg::CAP_W-1:0]  csr_wdata
);
   import lfu_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             req_valid_ff, req_valid_in;
   req_item_type     req_item_ff, req_item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in, store_result;
   logic             req_xfer, fire;

   // The request register holds one item; it is processed as soon as the
   // response register is empty or being drained in the same cycle.
   assign fire       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || fire;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      req_item_in.action = req_tuser;
      req_item_in.key    = req_tdata[KEY_W-1:0];
      req_item_in.value  = req_tdata[KEY_W+VALUE_W-1:KEY_W];
   end

   assign capacity_in = csr_wen ? csr_wdata : capacity_ff;

   always_comb begin
      if (req_xfer) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_item_in = fire ? store_result : rsp_item_ff;
   end

   // all lookup, replacement and bookkeeping for the held item
   lfu_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (req_item_ff),
      .capacity (capacity_ff),
      .result   (store_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, loaded only on a transfer or when processed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_item_ff <= req_item_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.evicted_key, rsp_item_ff.read_value};
   assign rsp_tuser  = {rsp_item_ff.evicted, rsp_item_ff.hit};

endmodule

### sv/lfu_victim.sv
// Min reduction over all valid entries: lowest use count, oldest among equals.
module lfu_victim #(
   parameter int N      = 16,
   parameter int IDX_W  = (N > 1) ? $clog2(N) : 1,
   parameter int RANK_W = IDX_W
) (
   input  logic [N-1:0]                valid,
   input  logic [lfu_pkg::COUNT_W-1:0] count [N],
   input  logic [RANK_W-1:0]           rank  [N],
   output logic [IDX_W-1:0]            victim_idx,
   output logic [RANK_W-1:0]           victim_rank
);
   import lfu_pkg::*;

   localparam int LVL = (N > 1) ? $clog2(N) : 0;
   localparam int P   = 1 << LVL;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] cnt;
      logic [RANK_W-1:0]  rnk;
      logic [IDX_W-1:0]   idx;
   } node_type;

   node_type nodes [2*P-1];

   function automatic logic left_wins(node_type a, node_type b);
      logic r;
      r = a.ok && (!b.ok || (a.cnt < b.cnt) || ((a.cnt == b.cnt) && (a.rnk > b.rnk)));
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < P; i++) begin
         if (i < N) begin
            nodes[P-1+i].ok  = valid[i];
            nodes[P-1+i].cnt = count[i];
            nodes[P-1+i].rnk = rank[i];
            nodes[P-1+i].idx = IDX_W'(i);
         end else begin
            nodes[P-1+i] = '0;
         end
      end
      for (int j = P - 2; j >= 0; j--) begin
         nodes[j] = left_wins(nodes[2*j+1], nodes[2*j+2]) ? nodes[2*j+1] : nodes[2*j+2];
      end
   end

   assign victim_idx  = nodes[0].idx;
   assign victim_rank = nodes[0].rnk;

endmodule

### sv/lfu_store.sv
// Entry store: lookup, victim choice, state update; one item per cycle with fire.
module lfu_store #(
   parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  lfu_pkg::req_item_type       item,
   input  logic [lfu_pkg::CAP_W-1:0]   capacity,
   output lfu_pkg::rsp_item_type       result
);
   import lfu_pkg::*;

   localparam int N      = MAX_ENTRIES;
   localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(N + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [N-1:0]         valid_ff, valid_in, match;
   logic [KEY_W-1:0]     key_ff   [N];
   logic [KEY_W-1:0]     key_in   [N];
   logic [VALUE_W-1:0]   data_ff  [N];
   logic [VALUE_W-1:0]   data_in  [N];
   logic [COUNT_W-1:0]   count_ff [N];
   logic [COUNT_W-1:0]   count_in [N];
   logic [RANK_W-1:0]    rank_ff  [N];
   logic [RANK_W-1:0]    rank_in  [N];
   logic [OCC_W-1:0]     occ_ff, occ_in;

   logic [CMP_W-1:0]     cap_ext, eff_cap;
   logic                 cap_on, is_put, hit, insert, evict, found;
   logic [VALUE_W-1:0]   hit_data;
   logic [RANK_W-1:0]    hit_rank, victim_rank;
   logic [IDX_W-1:0]     victim_idx, free_idx;

   lfu_victim #(
      .N      (N),
      .IDX_W  (IDX_W),
      .RANK_W (RANK_W)
   ) u_victim (
      .valid       (valid_ff),
      .count       (count_ff),
      .rank        (rank_ff),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank)
   );

   // capacity above the entry count acts as a full-size store
   assign cap_ext = CMP_W'(capacity);
   assign eff_cap = (cap_ext > CMP_W'(N)) ? CMP_W'(N) : cap_ext;
   assign cap_on  = (capacity != '0);
   assign is_put  = (item.action == ACTION_PUT);

   // lookup; keys are unique so the match vector is one-hot or empty
   always_comb begin
      match    = '0;
      hit_data = '0;
      hit_rank = '0;
      for (int i = 0; i < N; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == item.key);
         if (match[i]) begin
            hit_data = hit_data | data_ff[i];
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      hit    = cap_on && (|match);
      insert = cap_on && !(|match) && is_put;
      evict  = insert && (CMP_W'(occ_ff) >= eff_cap);

      // first free slot, counting the victim's slot as free
      free_idx = '0;
      found    = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (!found && (!valid_ff[i] || (evict && (victim_idx == IDX_W'(i))))) begin
            free_idx = IDX_W'(i);
            found    = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      occ_in   = occ_ff;
      if (fire) begin
         for (int i = 0; i < N; i++) begin
            if (hit) begin
               if (match[i]) begin
                  if (count_ff[i] != '1) begin
                     count_in[i] = count_ff[i] + 1'b1;
                  end
                  rank_in[i] = '0;
                  if (is_put) begin
                     data_in[i] = item.value;
                  end
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end else if (insert) begin
               if (free_idx == IDX_W'(i)) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = item.key;
                  data_in[i]  = item.value;
                  count_in[i] = COUNT_W'(1);
                  rank_in[i]  = '0;
               end else if (evict && (victim_idx == IDX_W'(i))) begin
                  valid_in[i] = 1'b0;
               end else if (valid_ff[i] && !(evict && (rank_ff[i] > victim_rank))) begin
                  // eviction closes the gap above the victim, insert pushes all down
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end
         if (insert && !evict) begin
            occ_in = occ_ff + 1'b1;
         end
      end
   end

   always_comb begin
      result.hit         = hit;
      result.read_value  = (hit && !is_put) ? {1'b0, hit_data} : '1;
      result.evicted     = evict;
      result.evicted_key = evict ? key_ff[victim_idx] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      data_ff  <= data_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key present in more than one entry");

   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid entries");

   a_evict_keeps_occ: assert property (@(posedge clock) disable iff (reset)
      fire && evict |=> occ_ff == $past(occ_ff))
      else $error("evict-and-insert changed occupancy");

   a_insert_grows_occ: assert property (@(posedge clock) disable iff (reset)
      fire && insert && !evict |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("insert without eviction did not grow occupancy");

endmodule

### dv/lfu_checker.sv
`timescale 1ns / 100ps
// Watches both channels and the capacity port, tracks the LFU store and
// compares every response transfer with the oldest predicted one.
module lfu_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [63:0]                req_tdata,
   input  logic                       req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [63:0]                rsp_tdata,
   input  logic [1:0]                 rsp_tuser,
   input  logic                       csr_wen,
   input  logic [lfu_pkg::CAP_W-1:0]  csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   import lfu_pkg::*;

   logic [CAP_W-1:0]          cap_reg;
   logic                      valid_q [MAX_ENTRIES];
   logic signed [KEY_W-1:0]   key_q   [MAX_ENTRIES];
   logic [VALUE_W-1:0]        data_q  [MAX_ENTRIES];
   logic [COUNT_W-1:0]        use_q   [MAX_ENTRIES];
   int unsigned               rank_q  [MAX_ENTRIES];
   int unsigned               occupancy;
   rsp_item_type              expected_rsp_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // rank 0 is the newest entry; entries newer than bound age by one
   function automatic void make_recent(int slot, int unsigned bound);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (valid_q[i] && i != slot && rank_q[i] < bound) rank_q[i]++;
      end
      rank_q[slot] = 0;
   endfunction

   function automatic rsp_item_type cache_access(req_item_type req);
      rsp_item_type res;
      int unsigned  eff_cap;
      int unsigned  gone_rank;
      int           slot;
      int           victim;
      res.hit         = 1'b0;
      res.read_value  = -1;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      eff_cap = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
      if (eff_cap == 0) return res;
      slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (slot < 0 && valid_q[i] && key_q[i] == req.key) slot = i;
      end
      if (slot >= 0) begin
         res.hit = 1'b1;
         if (req.action == ACTION_PUT) data_q[slot] = req.value;
         else res.read_value = {1'b0, data_q[slot]};
         if (use_q[slot] != '1) use_q[slot]++;
         make_recent(slot, rank_q[slot]);
      end else if (req.action == ACTION_PUT) begin
         if (occupancy >= eff_cap) begin
            // lowest count first, oldest among equal counts
            victim = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_q[i] && (victim < 0 || use_q[i] < use_q[victim] ||
                   (use_q[i] == use_q[victim] && rank_q[i] > rank_q[victim])))
                  victim = i;
            end
            if (victim >= 0) begin
               res.evicted     = 1'b1;
               res.evicted_key = key_q[victim];
               gone_rank       = rank_q[victim];
               valid_q[victim] = 1'b0;
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (valid_q[i] && rank_q[i] > gone_rank) rank_q[i]--;
               end
               if (occupancy > 0) occupancy--;
            end
         end
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot < 0 && !valid_q[i]) slot = i;
         end
         if (slot >= 0) begin
            valid_q[slot] = 1'b1;
            key_q[slot]   = req.key;
            data_q[slot]  = req.value;
            use_q[slot]   = 1;
            make_recent(slot, 32'hFFFF_FFFF);
            occupancy++;
         end
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_item_type req;
      if (reset) begin
         cap_reg   = CAP_RESET;
         occupancy = 0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_q[i] = 1'b0;
            key_q[i]   = '0;
            data_q[i]  = '0;
            use_q[i]   = '0;
            rank_q[i]  = 0;
         end
         expected_rsp_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none expected, actual data %h user %b",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_tuser[0]));
               check_field("read_value", want.read_value, rsp_tdata[31:0]);
               check_field("evicted", 32'(want.evicted), 32'(rsp_tuser[1]));
               check_field("evicted_key", want.evicted_key, rsp_tdata[63:32]);
            end
         end
         if (csr_wen) cap_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            req.action = req_tuser;
            req.key    = req_tdata[31:0];
            req.value  = req_tdata[62:32];
            expected_rsp_q.push_back(cache_access(req));
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

### dv/tb_lfu_cache_with_lru_tiebreak.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the LFU cache. Prediction and comparison live in
// lfu_checker; this module only drives the channels and the capacity port.
module tb_lfu_cache_with_lru_tiebreak;

   import lfu_pkg::*;

   localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
   // idle cycles (no transfer on either channel) before we give up
   localparam int IDLE_LIMIT  = 2000;
   localparam int POOL_SIZE   = 24;
   localparam int HOT_KEYS    = 8;
   localparam int PHASE_ITEMS = 84;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic [VALUE_W-1:0]      VAL_MAX = '1;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [63:0]        req_tdata;   // key[31:0], value[62:32], zero[63]
   logic               req_tuser;   // action
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [63:0]        rsp_tdata;   // read_value[31:0], evicted_key[63:32]
   logic [1:0]         rsp_tuser;   // hit[0], evicted[1]
   logic               csr_wen;
   logic [CAP_W-1:0]   csr_wdata;

   int                 fail_count;
   int                 pending;
   int                 idle_cycles;
   logic               sender_steady;   // no request gaps while set
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];
   int                 phase_caps [11];

   lfu_cache_with_lru_tiebreak #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   lfu_checker #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Response back-pressure: mostly short stalls, a few long ones, and in every
   // fourth window of cycles no new stall starts and tready is held high.
   initial begin : rsp_pacing
      int stall_left;
      int cycle_no;
      int roll;
      stall_left = 0;
      cycle_no   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if ((cycle_no / 512) % 4 != 3) begin
               roll = $urandom_range(0, 99);
               if (roll < 12) stall_left = $urandom_range(1, 3);
               else if (roll < 14) stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   // with tvalid still high, so back-to-back requests never drop tvalid.
   task automatic send_req(input logic act, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {1'b0, val, key};
      req_tuser  = act;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Capacity changes only once the cache has drained.
   task automatic write_capacity(input int cap);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wdata = CAP_W'(cap);
      csr_wen   = 1'b1;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   // Mostly gets/puts on a small key pool (hot subset weighted) so hits,
   // frequency ties and evictions are common; the rest are fresh random keys.
   task automatic send_random_req();
      logic               act;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] val;
      int                 roll;
      act  = ($urandom_range(0, 99) < 50) ? ACTION_PUT : ACTION_GET;
      roll = $urandom_range(0, 99);
      if (roll < 65) key = key_pool[$urandom_range(0, HOT_KEYS - 1)];
      else if (roll < 90) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 5) val = '0;
      else if (roll < 10) val = VAL_MAX;
      else val = VALUE_W'($urandom);
      send_req(act, key, val);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = ACTION_GET;
      csr_wen       = 1'b0;
      csr_wdata     = '0;
      idle_cycles   = 0;
      sender_steady = 1'b0;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      phase_caps = '{31, 4, 1, 17, 0, 3, 16, 2, 8, 5, 16};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed: full capacity, extremes of key and value
      write_capacity(16);
      send_req(ACTION_GET, '0, '0);            // miss on empty store
      send_req(ACTION_PUT, KEY_MIN, '0);
      send_req(ACTION_PUT, KEY_MAX, VAL_MAX);
      send_req(ACTION_GET, KEY_MIN, VAL_MAX);  // hit, value ignored on get
      send_req(ACTION_GET, KEY_MAX, '0);
      send_req(ACTION_PUT, KEY_MIN, 31'd12345);  // put hit: value replaced
      send_req(ACTION_GET, KEY_MIN, '0);
      send_req(ACTION_PUT, '1, 31'd5);
      send_req(ACTION_PUT, '0, 31'd6);
      send_req(ACTION_GET, '0, '0);

      // zero capacity: everything misses, puts do nothing, entries survive
      write_capacity(0);
      send_req(ACTION_GET, KEY_MIN, '0);
      send_req(ACTION_PUT, 32'd7, 31'd1);
      send_req(ACTION_GET, 32'd7, '0);

      // capacity below occupancy (4 stored): each put miss evicts one first
      write_capacity(2);
      send_req(ACTION_PUT, 32'd100, 31'd1);    // evicts the only count-1 key
      send_req(ACTION_PUT, 32'd101, 31'd2);
      send_req(ACTION_GET, '0, '0);
      send_req(ACTION_GET, KEY_MAX, '0);
      send_req(ACTION_PUT, 32'd102, 31'd3);
      send_req(ACTION_GET, 32'd102, '0);
      send_req(ACTION_PUT, 32'd103, 31'd4);
      send_req(ACTION_PUT, 32'd104, 31'd5);
      send_req(ACTION_GET, 32'd104, '0);
      send_req(ACTION_GET, 32'd104, '0);
      // lowest count now shared by three keys: the least recent of them goes
      send_req(ACTION_PUT, 32'd105, 31'd6);

      // --- random phases, one capacity setting each; the capacity write
      // also makes the sender wait until every response has come back
      for (int p = 0; p < 11; p++) begin
         write_capacity(phase_caps[p]);
         sender_steady = (p % 4 == 2);
         repeat (PHASE_ITEMS) send_random_req();
      end

      // --- drain and verdict
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
sv/lfu_pkg.sv
sv/lfu_victim.sv
sv/lfu_store.sv
sv/lfu_cache_with_lru_tiebreak.sv
dv/lfu_checker.sv
dv/tb_lfu_cache_with_lru_tiebreak.sv
